// ===== hw/rtl/mesh_max_displacement_convergence_defines.svh =====
// assertion macros for the mesh displacement convergence monitor
`ifndef MESH_MAX_DISPLACEMENT_CONVERGENCE_DEFINES_SVH
`define MESH_MAX_DISPLACEMENT_CONVERGENCE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define MMDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmdc: same-cycle check failed");
// next-cycle implication
`define MMDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmdc: next-cycle check failed");
`else
`define MMDC_ASSERT_IMP(lbl, ante, cons)
`define MMDC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/mmdc_pkg.sv =====
`default_nettype none
package mmdc_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W = 32;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int DIST_W  = 33;
    localparam int ITER_W  = 16;
    localparam int THR_W   = 33;

    // digit-by-digit root: two radicand bits per step
    localparam int ROOT_W     = (SUM_W + 1) / 2 + 1;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int RCNT_W     = $clog2(ROOT_STEPS);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(65536);
    localparam logic [ITER_W-1:0] MIN_ITER_RST  = ITER_W'(1);
    localparam logic [ITER_W-1:0] MAX_ITER_RST  = ITER_W'(1000);
    localparam logic [ITER_W-1:0] ITER_SAT      = '1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_ITER  = 2'd1;
    localparam logic [1:0] REG_MAX_ITER  = 2'd2;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      last_vertex;
    } t_in_item;

    typedef struct packed {
        logic              converged;
        logic [DIST_W-1:0] max_distance;
        logic [ITER_W-1:0] iteration;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [ITER_W-1:0] min_iterations;
        logic [ITER_W-1:0] max_iterations;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_FIN,
        S_ROOT
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/mesh_max_displacement_convergence.sv =====
// mesh displacement convergence monitor. vertices come in one transaction
// each; a load pass (command 0) fills the reference store and clears the
// check count, a check pass (command 1) measures every vertex against the
// stored one at the same index, keeps the largest squared move and writes
// the vertex back. the last vertex of a check pass yields one result
// transaction: floor root of the largest squared move, the saturating check
// count and the verdict against threshold, min_iterations, max_iterations.
// sequence: a load vertex, or a check vertex with no stored partner, goes from
// idle straight to the finish state; a compared vertex first waits in the calc
// state on the shared 32x32 squarer doing x, y and z in turn; the last vertex
// of a check pass then runs the bit-serial root unit (one result bit per cycle)
// and waits for the output register to free up. a result waiting at the output
// does not block new input. the reference store is not cleared after reset.
`default_nettype none
`include "mesh_max_displacement_convergence_defines.svh"
module mesh_max_displacement_convergence
    import mmdc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // vertex input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_data,
    // verdict output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_data
);

    t_cfg w_cfg;

    mmdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // state
    t_state            r_state;
    t_state            n_state;
    t_in_item          r_item;
    t_vec              r_ref;
    logic              r_cmp;
    logic [CNT_W-1:0]  r_pass_index;
    logic [CNT_W-1:0]  r_stored_count;
    logic [SUM_W-1:0]  r_max;
    logic [ITER_W-1:0] r_check_count;
    logic              r_out_valid;
    t_out_item         r_out;

    // reference store, no reset
    t_vec              r_mem [MAX_VERTICES];

    // sequencer outputs
    logic              w_in_acc;
    logic              w_cmp_now;
    logic              w_dist_start;
    logic              w_root_start;
    logic              w_fin;
    logic              w_out_load;
    logic              w_out_free;

    logic              w_dist_busy;
    logic [SUM_W-1:0]  w_dist_sum;
    logic              w_root_busy;
    logic [DIST_W-1:0] w_root;
    logic [SUM_W-1:0]  w_new_max;
    logic [ADDR_W-1:0] w_addr;
    logic              w_in_range;
    logic              w_conv;
    t_vec              w_pos;

    assign w_addr     = r_pass_index[ADDR_W-1:0];
    assign w_in_range = r_pass_index < CNT_W'(MAX_VERTICES);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cmp_now  = (i_in_data.command == CMD_CHECK) && (r_pass_index < r_stored_count);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_pos      = '{x: r_item.pos_x, y: r_item.pos_y, z: r_item.pos_z};

    mmdc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dist_start),
        .i_pos   (w_pos),
        .i_ref   (r_ref),
        .o_busy  (w_dist_busy),
        .o_sum   (w_dist_sum)
    );

    // running maximum including the vertex now finishing
    assign w_new_max = (r_cmp && (w_dist_sum > r_max)) ? w_dist_sum : r_max;

    mmdc_root u_root (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_root_start),
        .i_operand (w_new_max),
        .o_busy    (w_root_busy),
        .o_root    (w_root)
    );

    // verdict: below min never, at or above max always, else by threshold
    always_comb begin
        if (r_check_count < w_cfg.min_iterations) begin
            w_conv = 1'b0;
        end else if (r_check_count >= w_cfg.max_iterations) begin
            w_conv = 1'b1;
        end else begin
            w_conv = w_root < w_cfg.threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_stall   = 1'b1;
        w_dist_start = 1'b0;
        w_root_start = 1'b0;
        w_fin        = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    w_dist_start = w_cmp_now;
                    n_state      = w_cmp_now ? S_CALC : S_FIN;
                end
            end
            S_CALC: begin
                if (!w_dist_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_fin = 1'b1;
                if (r_item.command == CMD_CHECK && r_item.last_vertex) begin
                    w_root_start = 1'b1;
                    n_state      = S_ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                if (!w_root_busy && w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // pass bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_index   <= '0;
            r_stored_count <= '0;
            r_max          <= '0;
            r_check_count  <= '0;
        end else if (w_fin) begin
            if (r_item.last_vertex) begin
                // count of the pass, capped at capacity
                r_stored_count <= w_in_range ? r_pass_index + 1'b1 : r_pass_index;
                r_pass_index   <= '0;
                r_max          <= '0;
            end else begin
                if (w_in_range) begin
                    r_pass_index <= r_pass_index + 1'b1;
                end
                r_max <= w_new_max;
            end
            if (r_item.command == CMD_LOAD) begin
                r_check_count <= '0;
            end else if (r_item.last_vertex && r_check_count != ITER_SAT) begin
                r_check_count <= r_check_count + 1'b1;
            end
        end
    end

    // transaction capture and reference read
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_data;
            r_cmp  <= w_cmp_now;
            r_ref  <= r_mem[w_addr];
        end
    end

    // write-back of the vertex while it fits
    always_ff @(posedge i_clk) begin
        if (w_fin && w_in_range) begin
            r_mem[w_addr] <= w_pos;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.converged    <= w_conv;
            r_out.max_distance <= w_root;
            r_out.iteration    <= r_check_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // root unit runs only while the sequencer waits on it
    `MMDC_ASSERT_IMP(a_root_in_root_state, w_root_busy, r_state == S_ROOT)
    // a result only appears out of the root wait
    `MMDC_ASSERT_IMP(a_out_from_root, $rose(r_out_valid), $past(r_state) == S_ROOT)
    // pass index and stored count stay within capacity
    `MMDC_ASSERT_IMP(a_index_bound, 1'b1, r_pass_index <= CNT_W'(MAX_VERTICES))
    `MMDC_ASSERT_IMP(a_count_bound, 1'b1, r_stored_count <= CNT_W'(MAX_VERTICES))
    // a load vertex clears the check count
    `MMDC_ASSERT_NXT(a_load_clears_count, w_fin && r_item.command == CMD_LOAD, r_check_count == '0)

endmodule
`default_nettype wire

// ===== hw/rtl/mmdc_cfg.sv =====
`default_nettype none
module mmdc_cfg
    import mmdc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[PADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold      <= THRESHOLD_RST;
            r_cfg.min_iterations <= MIN_ITER_RST;
            r_cfg.max_iterations <= MAX_ITER_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD: r_cfg.threshold      <= pwdata[THR_W-1:0];
                REG_MIN_ITER:  r_cfg.min_iterations <= pwdata[ITER_W-1:0];
                REG_MAX_ITER:  r_cfg.max_iterations <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THRESHOLD: prdata = PDATA_W'(r_cfg.threshold);
            REG_MIN_ITER:  prdata = PDATA_W'(r_cfg.min_iterations);
            REG_MAX_ITER:  prdata = PDATA_W'(r_cfg.max_iterations);
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mmdc_dist.sv =====
`default_nettype none
module mmdc_dist
    import mmdc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_vec             i_pos,
    input  wire t_vec             i_ref,
    output logic                  o_busy,
    output logic      [SUM_W-1:0] o_sum
);

    // step 0..2 take a difference, 1..3 square it, 2..4 add it up
    logic               r_busy;
    logic [2:0]         r_step;
    logic [COORD_W-1:0] r_diff;
    logic [PROD_W-1:0]  r_prod;
    logic [SUM_W-1:0]   r_sum;

    logic [COORD_W-1:0] w_a;
    logic [COORD_W-1:0] w_b;
    logic [COORD_W:0]   w_ab;
    logic [COORD_W:0]   w_ba;
    logic [PROD_W-1:0]  w_sq;

    always_comb begin
        case (r_step[1:0])
            2'd0:    begin w_a = i_pos.x; w_b = i_ref.x; end
            2'd1:    begin w_a = i_pos.y; w_b = i_ref.y; end
            default: begin w_a = i_pos.z; w_b = i_ref.z; end
        endcase
    end

    assign w_ab = {w_a[COORD_W-1], w_a} - {w_b[COORD_W-1], w_b};
    assign w_ba = {w_b[COORD_W-1], w_b} - {w_a[COORD_W-1], w_a};
    assign w_sq = r_diff * r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd4) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= '0;
        end else if (r_busy) begin
            r_diff <= w_ab[COORD_W] ? w_ba[COORD_W-1:0] : w_ab[COORD_W-1:0];
            r_prod <= w_sq;
            if (r_step >= 3'd2) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_sum  = r_sum;

endmodule
`default_nettype wire

// ===== hw/rtl/mmdc_root.sv =====
`default_nettype none
module mmdc_root
    import mmdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_operand,
    output logic                   o_busy,
    output logic      [DIST_W-1:0] o_root
);

    logic              r_busy;
    logic [RCNT_W-1:0] r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_sub;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;

    // restoring square root, one result bit per cycle
    assign w_trial = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_sub   = {1'b0, r_root, 2'b01};
    assign w_ge    = w_trial >= w_sub;
    assign w_diff  = w_trial - w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= RCNT_W'(ROOT_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_operand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root[DIST_W-1:0];

endmodule
`default_nettype wire
